@@ design/ntpc_pkg.sv @@
// Shared types and constants for the SNTP response check and offset block.
// No dependencies; used by every other file of the block.
package ntpc_pkg;

    localparam logic [1:0] OP_SENT     = 2'd0;
    localparam logic [1:0] OP_RESPONSE = 2'd1;

    localparam logic [1:0] ST_SUCCESS = 2'd0;
    localparam logic [1:0] ST_RETRY   = 2'd1;
    localparam logic [1:0] ST_GIVE_UP = 2'd2;

    localparam logic [3:0] FC_NONE     = 4'd0;
    localparam logic [3:0] FC_SOURCE   = 4'd1;
    localparam logic [3:0] FC_PORT     = 4'd2;
    localparam logic [3:0] FC_LENGTH   = 4'd3;
    localparam logic [3:0] FC_MODE     = 4'd4;
    localparam logic [3:0] FC_STRATUM  = 4'd5;
    localparam logic [3:0] FC_UNSYNCED = 4'd6;
    localparam logic [3:0] FC_RTT      = 4'd7;
    localparam logic [3:0] FC_TIMEOUT  = 4'd8;

    localparam logic [1:0] CFG_ERA      = 2'd0;
    localparam logic [1:0] CFG_MAX_RTT  = 2'd1;
    localparam logic [1:0] CFG_MAX_ATT  = 2'd2;
    localparam logic [1:0] CFG_PORT     = 2'd3;

    localparam logic [33:0] NTP_DELTA_SEC = 34'd2208988800;
    localparam logic [33:0] ERA_SPAN      = 34'h1_0000_0000;
    localparam logic [63:0] NS_PER_S      = 64'd1000000000;
    localparam logic [63:0] NS_PER_MSEC   = 64'd1000000;
    localparam logic [15:0] MSG_BYTES     = 16'd48;
    localparam logic [2:0]  MODE_SERVER   = 3'd4;
    localparam logic [1:0]  LEAP_UNSYNCED = 2'd3;
    localparam logic [7:0]  STRATUM_LIMIT = 8'd16;

    // Bias that keeps the dividend non-negative: 2^33 seconds worth of ns.
    localparam int unsigned DIV_BITS    = 34;
    localparam logic [63:0] DIV_BIAS    = 64'd8589934592000000000;
    localparam logic [34:0] SEC_BIAS    = 35'h2_0000_0000;

    typedef struct packed {
        logic        era;
        logic [15:0] max_rtt_ms;
        logic [7:0]  max_attempts;
        logic [15:0] server_port;
    } t_cfg;

    typedef struct packed {
        logic [3:0]  cause;
        logic [63:0] rtt;
    } t_carry;

endpackage

@@ design/ntp_response_check_and_offset.sv @@
// SNTP response check, clock offset and round trip delay: top level.
// One item per cycle while no finished result waits on the output.
// Depth: five front stages, three divider stages and the output register.
// The whole pipeline holds while a finished result waits on the output.
// Synchronous active-low reset clears valids, send time and retry count and
// restores the register defaults.
module ntp_response_check_and_offset (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_addr,
    input  logic [15:0]   i_cfg_wdata,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // source_ok, source_port, message_length, first_byte, stratum, rx_seconds,
    // rx_fraction, tx_seconds, tx_fraction, local_sec, local_nsec
    input  logic [247:0]  i_s_axis_tdata,
    // operation
    input  logic [1:0]    i_s_axis_tuser,
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // fail_cause, offset_sec, offset_nsec, round_trip_ns
    output logic [135:0]  o_m_axis_tdata,
    // status
    output logic [1:0]    o_m_axis_tuser
);

    ntpc_pkg::t_cfg r_cfg;
    logic [7:0]     r_fail_count;

    logic           en;
    logic           accept;

    logic             front_valid;
    logic [63:0]      front_dividend;
    ntpc_pkg::t_carry front_carry;

    logic             div_valid;
    logic [ntpc_pkg::DIV_BITS-1:0] div_quotient;
    logic [29:0]      div_remainder;
    ntpc_pkg::t_carry div_carry;

    logic             r_out_valid;
    logic [1:0]       r_status;
    logic [3:0]       r_fail_cause;
    logic [34:0]      r_offset_sec;
    logic [29:0]      r_offset_nsec;
    logic [63:0]      r_round_trip;

    logic [7:0]       n_fail_count;
    logic [1:0]       n_status;
    logic [7:0]       fail_next;

    assign en     = !r_out_valid || i_m_axis_tready;
    assign accept = i_s_axis_tvalid && en;
    assign o_s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.era          <= 1'b0;
            r_cfg.max_rtt_ms   <= 16'd200;
            r_cfg.max_attempts <= 8'd3;
            r_cfg.server_port  <= 16'd123;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                ntpc_pkg::CFG_ERA:     r_cfg.era          <= i_cfg_wdata[0];
                ntpc_pkg::CFG_MAX_RTT: r_cfg.max_rtt_ms   <= i_cfg_wdata;
                ntpc_pkg::CFG_MAX_ATT: r_cfg.max_attempts <= i_cfg_wdata[7:0];
                ntpc_pkg::CFG_PORT:    r_cfg.server_port  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    ntpc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en),
        .i_accept         (accept),
        .i_cfg            (r_cfg),
        .i_operation      (i_s_axis_tuser),
        .i_source_ok      (i_s_axis_tdata[0]),
        .i_source_port    (i_s_axis_tdata[16:1]),
        .i_message_length (i_s_axis_tdata[32:17]),
        .i_first_byte     (i_s_axis_tdata[40:33]),
        .i_stratum        (i_s_axis_tdata[48:41]),
        .i_rx_seconds     (i_s_axis_tdata[80:49]),
        .i_rx_fraction    (i_s_axis_tdata[112:81]),
        .i_tx_seconds     (i_s_axis_tdata[144:113]),
        .i_tx_fraction    (i_s_axis_tdata[176:145]),
        .i_local_sec      (i_s_axis_tdata[210:177]),
        .i_local_nsec     (i_s_axis_tdata[240:211]),
        .o_valid          (front_valid),
        .o_dividend       (front_dividend),
        .o_carry          (front_carry)
    );

    ntpc_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (front_valid),
        .i_dividend  (front_dividend),
        .i_carry     (front_carry),
        .o_valid     (div_valid),
        .o_quotient  (div_quotient),
        .o_remainder (div_remainder),
        .o_carry     (div_carry)
    );

    // retry accounting, in item order at the pipeline end
    always_comb begin
        fail_next    = r_fail_count + 8'd1;
        n_fail_count = r_fail_count;
        n_status     = ntpc_pkg::ST_SUCCESS;
        if (div_carry.cause == ntpc_pkg::FC_NONE) begin
            n_fail_count = '0;
        end else if (fail_next >= r_cfg.max_attempts) begin
            n_fail_count = '0;
            n_status     = ntpc_pkg::ST_GIVE_UP;
        end else begin
            n_fail_count = fail_next;
            n_status     = ntpc_pkg::ST_RETRY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_fail_count <= '0;
        end else if (en) begin
            r_out_valid <= div_valid;
            if (div_valid) begin
                r_fail_count <= n_fail_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && div_valid) begin
            r_status     <= n_status;
            r_fail_cause <= div_carry.cause;
            if (div_carry.cause == ntpc_pkg::FC_NONE) begin
                r_offset_sec  <= {1'b0, div_quotient} - ntpc_pkg::SEC_BIAS;
                r_offset_nsec <= div_remainder;
                r_round_trip  <= div_carry.rtt;
            end else begin
                r_offset_sec  <= '0;
                r_offset_nsec <= '0;
                r_round_trip  <= (div_carry.cause == ntpc_pkg::FC_RTT &&
                                  n_status == ntpc_pkg::ST_RETRY) ? div_carry.rtt : 64'd0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_status;
    assign o_m_axis_tdata  = {3'd0, r_round_trip, r_offset_nsec, r_offset_sec, r_fail_cause};

endmodule

@@ design/ntpc_front.sv @@
// Front pipeline: header checks, timestamp conversion, d1/d2, offset dividend.
// Depends on ntpc_pkg; feeds ntpc_div.
module ntpc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_accept,
    input  ntpc_pkg::t_cfg       i_cfg,
    input  logic [1:0]           i_operation,
    input  logic                 i_source_ok,
    input  logic [15:0]          i_source_port,
    input  logic [15:0]          i_message_length,
    input  logic [7:0]           i_first_byte,
    input  logic [7:0]           i_stratum,
    input  logic [31:0]          i_rx_seconds,
    input  logic [31:0]          i_rx_fraction,
    input  logic [31:0]          i_tx_seconds,
    input  logic [31:0]          i_tx_fraction,
    input  logic [33:0]          i_local_sec,
    input  logic [29:0]          i_local_nsec,
    output logic                 o_valid,
    output logic [63:0]          o_dividend,
    output ntpc_pkg::t_carry     o_carry
);

    function automatic logic [33:0] ntp_to_unix(input logic [31:0] sec, input logic era);
        logic [33:0] pivot;
        logic [33:0] total;
        pivot = (era ? ntpc_pkg::ERA_SPAN : 34'd0) + ntpc_pkg::NTP_DELTA_SEC;
        total = {2'b00, sec};
        if (total < pivot) begin
            total = total + ntpc_pkg::ERA_SPAN;
        end
        return total - ntpc_pkg::NTP_DELTA_SEC;
    endfunction

    function automatic logic [29:0] frac_to_ns(input logic [31:0] frac);
        logic [61:0] prod;
        prod = {30'd0, frac} * 62'(ntpc_pkg::NS_PER_S);
        return prod[61:32];
    endfunction

    logic [33:0] r_sent_sec;
    logic [29:0] r_sent_nsec;
    logic [63:0] r_limit_ns;

    // stage A: input register
    logic        r_a_valid;
    logic        r_a_resp;
    logic        r_a_source_ok;
    logic [15:0] r_a_source_port;
    logic [15:0] r_a_message_length;
    logic [7:0]  r_a_first_byte;
    logic [7:0]  r_a_stratum;
    logic [31:0] r_a_rx_seconds;
    logic [31:0] r_a_rx_fraction;
    logic [31:0] r_a_tx_seconds;
    logic [31:0] r_a_tx_fraction;
    logic [33:0] r_a_local_sec;
    logic [29:0] r_a_local_nsec;
    logic [33:0] r_a_sent_sec;
    logic [29:0] r_a_sent_nsec;

    // stage B: checks and time differences
    logic        r_b_valid;
    logic [3:0]  r_b_cause;
    logic [35:0] r_b_ds1;
    logic [35:0] r_b_ds2;
    logic [63:0] r_b_dn1;
    logic [63:0] r_b_dn2;

    // stage C: d1, d2
    logic        r_c_valid;
    logic [3:0]  r_c_cause;
    logic [63:0] r_c_d1;
    logic [63:0] r_c_d2;

    // stage D: halved sum, round trip
    logic        r_d_valid;
    logic [63:0] r_d_total;
    ntpc_pkg::t_carry r_d_carry;

    // stage E: biased dividend
    logic        r_e_valid;
    logic [63:0] r_e_dividend;
    ntpc_pkg::t_carry r_e_carry;

    logic [3:0]  n_b_cause;
    logic [33:0] n_b_t1s;
    logic [33:0] n_b_t2s;
    logic [29:0] n_b_t1n;
    logic [29:0] n_b_t2n;
    logic [63:0] n_d_sum;
    logic [63:0] n_d_rtt;
    logic [63:0] n_d_half;
    logic [3:0]  n_d_cause;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent_sec  <= '0;
            r_sent_nsec <= '0;
        end else if (i_accept && i_operation == ntpc_pkg::OP_SENT) begin
            r_sent_sec  <= i_local_sec;
            r_sent_nsec <= i_local_nsec;
        end
    end

    always_ff @(posedge i_clk) begin
        r_limit_ns <= {48'd0, i_cfg.max_rtt_ms} * ntpc_pkg::NS_PER_MSEC;
    end

    always_comb begin
        if (!r_a_resp) begin
            n_b_cause = ntpc_pkg::FC_TIMEOUT;
        end else if (!r_a_source_ok) begin
            n_b_cause = ntpc_pkg::FC_SOURCE;
        end else if (r_a_source_port != i_cfg.server_port) begin
            n_b_cause = ntpc_pkg::FC_PORT;
        end else if (r_a_message_length != ntpc_pkg::MSG_BYTES) begin
            n_b_cause = ntpc_pkg::FC_LENGTH;
        end else if (r_a_first_byte[2:0] != ntpc_pkg::MODE_SERVER) begin
            n_b_cause = ntpc_pkg::FC_MODE;
        end else if (r_a_stratum == 8'd0 || r_a_stratum >= ntpc_pkg::STRATUM_LIMIT) begin
            n_b_cause = ntpc_pkg::FC_STRATUM;
        end else if (r_a_first_byte[7:6] == ntpc_pkg::LEAP_UNSYNCED) begin
            n_b_cause = ntpc_pkg::FC_UNSYNCED;
        end else begin
            n_b_cause = ntpc_pkg::FC_NONE;
        end
        n_b_t1s = ntp_to_unix(r_a_rx_seconds, i_cfg.era);
        n_b_t2s = ntp_to_unix(r_a_tx_seconds, i_cfg.era);
        n_b_t1n = frac_to_ns(r_a_rx_fraction);
        n_b_t2n = frac_to_ns(r_a_tx_fraction);
    end

    always_comb begin
        n_d_sum  = r_c_d1 + r_c_d2;
        n_d_rtt  = r_c_d1 - r_c_d2;
        // truncate toward zero: add one before the shift when negative
        n_d_half = n_d_sum + {63'd0, n_d_sum[63]};
        n_d_half = {n_d_half[63], n_d_half[63:1]};
        n_d_cause = r_c_cause;
        if (r_c_cause == ntpc_pkg::FC_NONE && $signed(n_d_rtt) > $signed(r_limit_ns)) begin
            n_d_cause = ntpc_pkg::FC_RTT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_accept && i_operation != ntpc_pkg::OP_SENT;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_resp           <= i_operation == ntpc_pkg::OP_RESPONSE;
            r_a_source_ok      <= i_source_ok;
            r_a_source_port    <= i_source_port;
            r_a_message_length <= i_message_length;
            r_a_first_byte     <= i_first_byte;
            r_a_stratum        <= i_stratum;
            r_a_rx_seconds     <= i_rx_seconds;
            r_a_rx_fraction    <= i_rx_fraction;
            r_a_tx_seconds     <= i_tx_seconds;
            r_a_tx_fraction    <= i_tx_fraction;
            r_a_local_sec      <= i_local_sec;
            r_a_local_nsec     <= i_local_nsec;
            r_a_sent_sec       <= r_sent_sec;
            r_a_sent_nsec      <= r_sent_nsec;

            r_b_cause <= n_b_cause;
            r_b_ds1   <= {2'b00, n_b_t1s} - {2'b00, r_a_sent_sec};
            r_b_ds2   <= {2'b00, n_b_t2s} - {2'b00, r_a_local_sec};
            r_b_dn1   <= {34'd0, n_b_t1n} - {34'd0, r_a_sent_nsec};
            r_b_dn2   <= {34'd0, n_b_t2n} - {34'd0, r_a_local_nsec};

            r_c_cause <= r_b_cause;
            r_c_d1    <= {{28{r_b_ds1[35]}}, r_b_ds1} * ntpc_pkg::NS_PER_S + r_b_dn1;
            r_c_d2    <= {{28{r_b_ds2[35]}}, r_b_ds2} * ntpc_pkg::NS_PER_S + r_b_dn2;

            r_d_total       <= n_d_half;
            r_d_carry.cause <= n_d_cause;
            r_d_carry.rtt   <= n_d_rtt;

            r_e_dividend <= r_d_total + ntpc_pkg::DIV_BIAS;
            r_e_carry    <= r_d_carry;
        end
    end

    assign o_valid    = r_e_valid;
    assign o_dividend = r_e_dividend;
    assign o_carry    = r_e_carry;

endmodule

@@ design/ntpc_div.sv @@
// Division of the biased offset by one billion through reciprocal multiplication,
// three pipeline stages. Depends on ntpc_pkg.
module ntpc_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [63:0]                         i_dividend,
    input  ntpc_pkg::t_carry                    i_carry,
    output logic                                o_valid,
    output logic [ntpc_pkg::DIV_BITS-1:0]       o_quotient,
    output logic [29:0]                         o_remainder,
    output ntpc_pkg::t_carry                    o_carry
);

    // 1e9 = 2^9 * 1953125. The dividend shifted right by 9 is below 2^55, so
    // ceil(2^76 / 1953125) as multiplier and a shift by 76 give the exact quotient.
    localparam logic [55:0] RECIP = 56'(((128'd1 << 76) + 128'd1953124) / 128'd1953125);

    logic [54:0]  xs;
    logic [27:0]  a0;
    logic [26:0]  a1;
    logic [111:0] n_prod;
    logic [63:0]  n_rem;

    // stage 1: partial products
    logic             r_valid1;
    logic [55:0]      r_p00;
    logic [55:0]      r_p01;
    logic [55:0]      r_p10;
    logic [55:0]      r_p11;
    logic [63:0]      r_x1;
    ntpc_pkg::t_carry r_carry1;

    // stage 2: quotient
    logic                          r_valid2;
    logic [ntpc_pkg::DIV_BITS-1:0] r_q2;
    logic [63:0]                   r_x2;
    ntpc_pkg::t_carry              r_carry2;

    // stage 3: remainder
    logic                          r_valid3;
    logic [ntpc_pkg::DIV_BITS-1:0] r_q3;
    logic [29:0]                   r_r3;
    ntpc_pkg::t_carry              r_carry3;

    assign xs = i_dividend[63:9];
    assign a0 = xs[27:0];
    assign a1 = xs[54:28];

    always_comb begin
        n_prod = {r_p11, 56'd0} + {28'd0, r_p01, 28'd0} + {28'd0, r_p10, 28'd0}
                 + {56'd0, r_p00};
        n_rem  = r_x2 - 64'(r_q2) * ntpc_pkg::NS_PER_S;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
            r_valid3 <= 1'b0;
        end else if (i_en) begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
            r_valid3 <= r_valid2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00    <= {28'd0, a0} * {28'd0, RECIP[27:0]};
            r_p01    <= {28'd0, a0} * {28'd0, RECIP[55:28]};
            r_p10    <= {29'd0, a1} * {28'd0, RECIP[27:0]};
            r_p11    <= {29'd0, a1} * {28'd0, RECIP[55:28]};
            r_x1     <= i_dividend;
            r_carry1 <= i_carry;

            r_q2     <= n_prod[76 +: ntpc_pkg::DIV_BITS];
            r_x2     <= r_x1;
            r_carry2 <= r_carry1;

            r_q3     <= r_q2;
            r_r3     <= n_rem[29:0];
            r_carry3 <= r_carry2;
        end
    end

    assign o_valid     = r_valid3;
    assign o_quotient  = r_q3;
    assign o_remainder = r_r3;
    assign o_carry     = r_carry3;

endmodule
